FILE: design/bc1_pkg.sv
// Shared types, constants and helpers for the BC1 block encoder.
// Used by bc1_block_encoder_unit; no dependencies of its own.
package bc1_pkg;

    localparam int BLOCK_PIXELS = 16;
    localparam int ADDR_W       = $clog2(BLOCK_PIXELS);
    localparam int COLOR_W      = 16;
    localparam int IDX_W        = 2;
    localparam int WORD_W       = 2 * COLOR_W + IDX_W * BLOCK_PIXELS;

    // floor(v*N/255) == (v*N*257 + 257) >> 16 for 8-bit v
    localparam logic [15:0] R5_MUL  = 16'd7967;
    localparam logic [15:0] G6_MUL  = 16'd16191;
    localparam logic [15:0] RND_ADD = 16'd257;

    localparam logic [COLOR_W-1:0] MAX_RESET = '0;
    localparam logic [COLOR_W-1:0] MIN_RESET = '1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // position on the max..min line to BC1 index
    function automatic logic [IDX_W-1:0] pos_to_index(input logic [1:0] pos);
        logic [IDX_W-1:0] idx;
        case (pos)
            2'd0:    idx = 2'd1;
            2'd1:    idx = 2'd3;
            2'd2:    idx = 2'd2;
            2'd3:    idx = 2'd0;
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

    function automatic logic [4:0] to5(input logic [7:0] v);
        logic [24:0] prod;
        prod = 25'(v) * 25'(R5_MUL) + 25'(RND_ADD);
        return prod[20:16];
    endfunction

    function automatic logic [5:0] to6(input logic [7:0] v);
        logic [24:0] prod;
        prod = 25'(v) * 25'(G6_MUL) + 25'(RND_ADD);
        return prod[21:16];
    endfunction

endpackage

FILE: design/bc1_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bc1_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bc1_block_encoder_unit.sv
// Top level of the BC1 block encoder: RGB888 pixels in, one 64-bit word per block out.
// Depends on bc1_pkg and bc1_ram.
//
//   channel | handshake           | word
//   --------+---------------------+-------------------------------
//   in      | in_valid / in_ready | red, green, blue (8 bits each)
//   out     | out_valid/out_ready | block_word (64 bits)
//
// A block takes 16 pixels, at one pixel a cycle while in_valid is high; then
// an index pass reads the pixel RAM back through its single read port, and then
// the word moves to the output register.
// rst_n clears control, count and running max/min; the pixel RAM is not cleared.
// in_ready is low during the index pass and while the finished word waits for
// a full output register; a new block loads while the output word is stalled.
module bc1_block_encoder_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       red,
    input  logic [7:0]                       green,
    input  logic [7:0]                       blue,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bc1_pkg::WORD_W-1:0]       block_word
);

    localparam int AW = bc1_pkg::ADDR_W;
    localparam int CW = bc1_pkg::COLOR_W;
    localparam int IW = bc1_pkg::IDX_W * bc1_pkg::BLOCK_PIXELS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(bc1_pkg::BLOCK_PIXELS - 1);

    bc1_pkg::state_t state_reg, state_next;

    logic [AW-1:0] count_reg, count_next;
    logic [CW-1:0] max_reg, max_next;
    logic [CW-1:0] min_reg, min_next;
    logic [AW:0]   scan_reg, scan_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [bc1_pkg::WORD_W-1:0] word_reg, word_next;

    // range registers for the index pass, refreshed every cycle
    logic [CW-1:0] d_reg;
    logic [CW+1:0] d3_reg;
    logic [CW+2:0] d5_reg;
    logic          flat_reg;

    logic          accept;
    logic [CW-1:0] pix;
    logic          issue;
    logic [CW-1:0] rdata;
    logic [CW-1:0] x;
    logic [CW+2:0] six;
    logic [1:0]    pos;
    logic [bc1_pkg::IDX_W-1:0] pix_idx;

    assign in_ready = (state_reg == bc1_pkg::ST_LOAD);
    assign accept   = in_valid && in_ready;
    assign pix      = {bc1_pkg::to5(red), bc1_pkg::to6(green), bc1_pkg::to5(blue)};
    assign issue    = (state_reg == bc1_pkg::ST_SCAN) && !scan_reg[AW];

    bc1_ram #(
        .WIDTH (CW),
        .DEPTH (bc1_pkg::BLOCK_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (count_reg),
        .wdata (pix),
        .raddr (scan_reg[AW-1:0]),
        .rdata (rdata)
    );

    // index of the pixel coming out of the RAM
    always_comb
    begin
        if (rdata <= min_reg)
        begin
            x = '0;
        end
        else
        begin
            x = rdata - min_reg;
        end
        if (x > d_reg)
        begin
            x = d_reg;
        end
        six = {1'b0, x, 2'b00} + {2'b00, x, 1'b0};
        pos = 2'(({1'b0, six > (CW+3)'(d_reg)}) + ({1'b0, six > (CW+3)'(d3_reg)})
              + ({1'b0, six > d5_reg}));
        pix_idx = flat_reg ? '0 : bc1_pkg::pos_to_index(pos);
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= max_reg - min_reg;
        d3_reg   <= (CW+2)'(max_reg - min_reg) * (CW+2)'(3);
        d5_reg   <= (CW+3)'(max_reg - min_reg) * (CW+3)'(5);
        flat_reg <= (max_reg <= min_reg);
        word_reg <= word_next;
        idx_reg  <= idx_next;
        rd_idx_reg <= rd_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bc1_pkg::ST_LOAD;
            count_reg     <= '0;
            max_reg       <= bc1_pkg::MAX_RESET;
            min_reg       <= bc1_pkg::MIN_RESET;
            scan_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            scan_reg      <= scan_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        scan_next      = scan_reg;
        rd_valid_next  = issue;
        rd_idx_next    = scan_reg[AW-1:0];
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        word_next      = word_reg;

        if (rd_valid_reg)
        begin
            // shift in from the top so pixel 0 ends in the low bits
            idx_next = {pix_idx, idx_reg[IW-1:bc1_pkg::IDX_W]};
        end

        case (state_reg)
            bc1_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (pix > max_reg)
                    begin
                        max_next = pix;
                    end
                    if (pix < min_reg)
                    begin
                        min_next = pix;
                    end
                    count_next = count_reg + AW'(1);
                    if (count_reg == LAST_ADDR)
                    begin
                        scan_next  = '0;
                        state_next = bc1_pkg::ST_SCAN;
                    end
                end
            end
            bc1_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    scan_next = scan_reg + (AW+1)'(1);
                end
                if (rd_valid_reg && rd_idx_reg == LAST_ADDR)
                begin
                    state_next = bc1_pkg::ST_EMIT;
                end
            end
            bc1_pkg::ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    word_next      = {idx_reg, min_reg, max_reg};
                    out_valid_next = 1'b1;
                    max_next       = bc1_pkg::MAX_RESET;
                    min_next       = bc1_pkg::MIN_RESET;
                    count_next     = '0;
                    state_next     = bc1_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = bc1_pkg::ST_LOAD;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign block_word = word_reg;

endmodule
